// ===== hdl/cfid_pkg.sv =====
// shared types, constants and scrambling functions of the cfi indicator detector
`default_nettype none

package cfid_pkg;

  localparam int unsigned SOFT_W     = 16;
  localparam int unsigned SUBFRAME_W = 4;
  localparam int unsigned CELL_ID_W  = 9;
  localparam int unsigned CFI_W      = 2;
  localparam int unsigned METRIC_W   = 22;
  localparam int unsigned POS_W      = 4;
  localparam int unsigned CINIT_W    = 24;
  localparam int unsigned GOLD_LEN   = 31;
  localparam int unsigned WORD_W     = 32;
  localparam int unsigned NUM_CW     = 3;
  localparam int unsigned GOLD_NC    = 1600;

  typedef logic signed [SOFT_W-1:0]   soft_t;
  typedef logic signed [METRIC_W-1:0] metric_t;
  typedef metric_t [NUM_CW-1:0]       metric_set_t;
  typedef logic [WORD_W-1:0][GOLD_LEN-1:0] gold_map_t;

  localparam logic [POS_W-1:0] LAST_POS     = 4'd15;
  localparam metric_t          START_METRIC = -22'sd16384;
  localparam logic [CFI_W-1:0] CFI_DEFAULT  = 2'd3;

  // codeword i has a zero at bit j exactly when j mod 3 == i
  localparam logic [NUM_CW-1:0][WORD_W-1:0] CW_MASK = {
    32'hDB6DB6DB, 32'h6DB6DB6D, 32'hB6DB6DB6
  };

  typedef struct packed {
    soft_t               real_soft;
    soft_t               imag_soft;
    logic [POS_W-1:0]    pos;
    logic                first;
    logic                last;
    logic [CINIT_W-1:0]  cinit;
  } queue_entry_t;

  // x2 run symbolically: each state bit as a mask over the c_init bits
  function automatic gold_map_t gold_x2_map();
    logic [GOLD_LEN-1:0][GOLD_LEN-1:0] st;
    logic [GOLD_LEN-1:0]               fb;
    gold_map_t                         map;
    map = '0;
    for (int b = 0; b < GOLD_LEN; b++) begin
      st[b] = GOLD_LEN'(1) << b;
    end
    for (int n = 0; n < GOLD_NC + WORD_W; n++) begin
      fb = st[0] ^ st[1] ^ st[2] ^ st[3];
      if (n >= GOLD_NC) begin
        map[5'(n - GOLD_NC)] = st[0];
      end
      for (int b = 0; b < GOLD_LEN - 1; b++) begin
        st[b] = st[b+1];
      end
      st[GOLD_LEN-1] = fb;
    end
    return map;
  endfunction

  // x1 starts at one, so its part of the output is fixed
  function automatic logic [WORD_W-1:0] gold_x1_word();
    logic [GOLD_LEN-1:0] x1;
    logic                f1;
    logic [WORD_W-1:0]   w;
    x1 = GOLD_LEN'(1);
    w  = '0;
    for (int n = 0; n < GOLD_NC + WORD_W; n++) begin
      f1 = x1[0] ^ x1[3];
      if (n >= GOLD_NC) begin
        w[5'(n - GOLD_NC)] = x1[0];
      end
      x1 = {f1, x1[GOLD_LEN-1:1]};
    end
    return w;
  endfunction

  localparam gold_map_t         GOLD_X2_MAP  = gold_x2_map();
  localparam logic [WORD_W-1:0] GOLD_X1_WORD = gold_x1_word();

  function automatic logic [WORD_W-1:0] gold_word(input logic [CINIT_W-1:0] cinit);
    logic [GOLD_LEN-1:0] c;
    logic [WORD_W-1:0]   w;
    c = GOLD_LEN'(cinit);
    for (int k = 0; k < WORD_W; k++) begin
      w[k] = GOLD_X1_WORD[k] ^ (^(GOLD_X2_MAP[k] & c));
    end
    return w;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/cfid_intf.sv =====
// channel interfaces: configuration, soft symbol input and cfi result
`default_nettype none

interface cfid_cfg_if;
  logic       valid;
  logic       ready;
  logic [8:0] cell_id;
  modport source (output valid, output cell_id, input ready);
  modport sink   (input valid, input cell_id, output ready);
endinterface

interface cfid_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] real_soft;
  logic signed [15:0] imag_soft;
  logic [3:0]         subframe;
  modport source (output valid, output real_soft, output imag_soft, output subframe,
                  input ready);
  modport sink   (input valid, input real_soft, input imag_soft, input subframe,
                  output ready);
endinterface

interface cfid_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         cfi;
  logic signed [21:0] best_metric;
  modport source (output valid, output cfi, output best_metric, input ready);
  modport sink   (input valid, input cfi, input best_metric, output ready);
endinterface

`default_nettype wire

// ===== hdl/cfid_front.sv =====
// front end: cell id register, symbol counter and scrambling seed per block
`default_nettype none

module cfid_front
  import cfid_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  cfid_cfg_if.sink    cfg_i,
  cfid_in_if.sink     sample_i,
  input  wire logic   queue_ready_i,
  output logic        push_o,
  output queue_entry_t entry_o
);

  logic [CELL_ID_W-1:0] cell_id_q, cell_id_d;
  logic [POS_W-1:0]     pos_q, pos_d;
  logic [9:0]           cell_x2p1;
  logic [4:0]           sf_p1;
  logic [14:0]          prod;

  assign cfg_i.ready    = 1'b1;
  assign sample_i.ready = queue_ready_i;
  assign push_o         = sample_i.valid && queue_ready_i;

  assign cell_id_d = cfg_i.valid ? cfg_i.cell_id : cell_id_q;
  assign pos_d     = push_o ? POS_W'(pos_q + 1'b1) : pos_q;

  // c_init = ((2*cell_id+1)*(1+subframe) << 9) + cell_id
  assign cell_x2p1 = {cell_id_q, 1'b1};
  assign sf_p1     = {1'b0, sample_i.subframe} + 5'd1;
  assign prod      = 15'(cell_x2p1) * 15'(sf_p1);

  always_comb begin
    entry_o.real_soft = sample_i.real_soft;
    entry_o.imag_soft = sample_i.imag_soft;
    entry_o.pos       = pos_q;
    entry_o.first     = (pos_q == '0);
    entry_o.last      = (pos_q == LAST_POS);
    entry_o.cinit     = {prod, 9'd0} + CINIT_W'(cell_id_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_id_q <= '0;
      pos_q     <= '0;
    end else begin
      cell_id_q <= cell_id_d;
      pos_q     <= pos_d;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/cfid_queue.sv =====
// short queue between front end and correlator
`default_nettype none

module cfid_queue
  import cfid_pkg::*;
#(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire queue_entry_t  wdata_i,
  output logic               ready_o,
  output logic               valid_o,
  input  wire logic          pop_i,
  output queue_entry_t       rdata_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  queue_entry_t     entries_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign ready_o = (count_q != CNT_W'(DEPTH));
  assign valid_o = (count_q != '0);
  assign rdata_o = entries_q[rd_ptr_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_q + 1'b1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_q + 1'b1);
    end
    if (do_push && !do_pop) begin
      count_d = CNT_W'(count_q + 1'b1);
    end else if (do_pop && !do_push) begin
      count_d = CNT_W'(count_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= wdata_i;
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("queue count above depth");
`endif

endmodule

`default_nettype wire

// ===== hdl/cfid_back.sv =====
// back end: gold word, descrambling and the three codeword accumulators
`default_nettype none

module cfid_back
  import cfid_pkg::*;
(
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          entry_valid_i,
  input  wire queue_entry_t  entry_i,
  output logic               entry_ready_o,
  input  wire logic          take_i,
  output logic               snap_valid_o,
  output metric_set_t        metrics_o
);

  logic                 adv, popped;
  logic [WORD_W-1:0]    word, scramble_q;
  logic [4:0]           idx_re, idx_im;
  soft_t                re_d, im_d;

  logic                 a_valid_q, a_first_q, a_last_q;
  logic [POS_W-1:0]     a_pos_q;
  soft_t                a_re_q, a_im_q;

  logic                 snap_valid_q, snap_valid_d;
  metric_set_t          metrics_q, metrics_d;

  // the whole back end holds while a finished block waits for the decision stage
  assign adv           = !snap_valid_q || take_i;
  assign entry_ready_o = adv;
  assign popped        = adv && entry_valid_i;

  // stage a: scrambling word, fresh on the first symbol of a block
  assign word   = entry_i.first ? gold_word(entry_i.cinit) : scramble_q;
  assign idx_re = {entry_i.pos, 1'b0};
  assign idx_im = {entry_i.pos, 1'b1};
  assign re_d   = word[idx_re] ? -entry_i.real_soft : entry_i.real_soft;
  assign im_d   = word[idx_im] ? -entry_i.imag_soft : entry_i.imag_soft;

  // stage b: correlate, the first symbol restarts the sums
  always_comb begin
    metric_t    ext_re, ext_im, term_re, term_im, base;
    logic [4:0] j_re, j_im;
    j_re   = {a_pos_q, 1'b0};
    j_im   = {a_pos_q, 1'b1};
    ext_re = METRIC_W'(a_re_q);
    ext_im = METRIC_W'(a_im_q);
    for (int i = 0; i < NUM_CW; i++) begin
      term_re      = CW_MASK[i][j_re] ? -ext_re : ext_re;
      term_im      = CW_MASK[i][j_im] ? -ext_im : ext_im;
      base         = a_first_q ? '0 : metrics_q[i];
      metrics_d[i] = base + term_re + term_im;
    end
  end

  assign snap_valid_d = a_valid_q && a_last_q;
  assign snap_valid_o = snap_valid_q;
  assign metrics_o    = metrics_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q    <= 1'b0;
      snap_valid_q <= 1'b0;
    end else if (adv) begin
      a_valid_q    <= entry_valid_i;
      snap_valid_q <= snap_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (popped) begin
      a_first_q <= entry_i.first;
      a_last_q  <= entry_i.last;
      a_pos_q   <= entry_i.pos;
      a_re_q    <= re_d;
      a_im_q    <= im_d;
      if (entry_i.first) begin
        scramble_q <= word;
      end
    end
    if (adv && a_valid_q) begin
      metrics_q <= metrics_d;
    end
  end

`ifndef SYNTH
  a_hold_finished: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (snap_valid_q && !take_i) |=> $stable(metrics_q))
    else $error("metrics changed while a finished block waits");

  a_last_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && a_valid_q && a_last_q) |=> snap_valid_q)
    else $error("last symbol did not mark the block finished");
`endif

endmodule

`default_nettype wire

// ===== hdl/cfid_decide.sv =====
// decision stage: picks the strongest codeword into the result register
`default_nettype none

module cfid_decide
  import cfid_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         snap_valid_i,
  input  wire metric_set_t  metrics_i,
  output logic              take_o,
  cfid_out_if.source        result_o
);

  logic             out_valid_q, out_valid_d;
  logic [CFI_W-1:0] cfi_q, cfi_d;
  metric_t          best_q, best_d;

  assign take_o = !out_valid_q || result_o.ready;

  // codewords tried in order, only a strictly larger metric wins
  always_comb begin
    best_d = START_METRIC;
    cfi_d  = CFI_DEFAULT;
    for (int i = 0; i < NUM_CW; i++) begin
      if ($signed(metrics_i[i]) > $signed(best_d)) begin
        best_d = metrics_i[i];
        cfi_d  = CFI_W'(i + 1);
      end
    end
  end

  assign out_valid_d = take_o ? snap_valid_i : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o && snap_valid_i) begin
      cfi_q  <= cfi_d;
      best_q <= best_d;
    end
  end

  assign result_o.valid       = out_valid_q;
  assign result_o.cfi         = cfi_q;
  assign result_o.best_metric = best_q;

`ifndef SYNTH
  a_load_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (snap_valid_i && take_o) |=> out_valid_q)
    else $error("finished block not loaded into result register");

  a_winner_above_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ((cfi_q == CFI_DEFAULT) || ($signed(best_q) > $signed(START_METRIC))))
    else $error("non-default cfi without metric above start");
`endif

endmodule

`default_nettype wire

// ===== hdl/cfi_indicator_detect.sv =====
// A block's last symbol passes queue, stage a and accumulators into the result register.
// Throughput: one symbol per cycle while the queue has room; one result per 16 symbols.
// The correlator pipeline holds only while a result waits in the output register; the
// input queue of QUEUE_DEPTH entries keeps taking symbols meanwhile until it is full.
// Reset: asynchronous, active low; clears cell_id to 0, the symbol count, queue and valids.
`default_nettype none

module cfi_indicator_detect
  import cfid_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  cfid_cfg_if.sink    cfg_i,
  cfid_in_if.sink     sample_i,
  cfid_out_if.source  result_o
);

  logic         push, queue_ready, queue_valid, pop;
  queue_entry_t push_entry, head_entry;
  logic         snap_valid, take;
  metric_set_t  metrics;

  cfid_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_i),
    .sample_i      (sample_i),
    .queue_ready_i (queue_ready),
    .push_o        (push),
    .entry_o       (push_entry)
  );

  cfid_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_entry),
    .ready_o (queue_ready),
    .valid_o (queue_valid),
    .pop_i   (pop),
    .rdata_o (head_entry)
  );

  cfid_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .entry_valid_i (queue_valid),
    .entry_i       (head_entry),
    .entry_ready_o (pop),
    .take_i        (take),
    .snap_valid_o  (snap_valid),
    .metrics_o     (metrics)
  );

  cfid_decide u_decide (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .snap_valid_i (snap_valid),
    .metrics_i    (metrics),
    .take_o       (take),
    .result_o     (result_o)
  );

endmodule

`default_nettype wire

// ===== sim/cfi_indicator_detect_tb.sv =====
// self-checking testbench for the cfi indicator detector: directed rows, then shaped random blocks
module cfi_indicator_detect_tb
  import cfid_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SETTLE_CYCLES    = 20;
  localparam int unsigned LONG_HOLD_CYCLES = 300;
  localparam int unsigned BLOCKS_PER_PHASE = 19;
  localparam int unsigned NUM_PHASES       = 3;
  localparam int unsigned NUM_DIRECTED     = 25;
  localparam int unsigned NUM_EXTREMES     = 5;
  localparam int unsigned NUM_CELL_PRESETS = 6;

  localparam soft_t SOFT_MIN = 16'sh8000;
  localparam soft_t SOFT_MAX = 16'sh7fff;

  localparam int unsigned SEND_IDLE [NUM_PHASES] = '{31, 78, 0};
  localparam int unsigned RECV_IDLE [NUM_PHASES] = '{78, 31, 0};
  localparam soft_t EXTREME_SOFT [NUM_EXTREMES] = '{SOFT_MIN, SOFT_MAX, 16'sd0, -16'sd1, 16'sd1};
  localparam logic [CELL_ID_W-1:0] CELL_PRESETS [NUM_CELL_PRESETS] =
    '{9'd0, 9'd504, 9'd503, 9'd255, 9'd511, 9'd1};

  typedef struct packed {
    logic [CFI_W-1:0] cfi;
    metric_t          best_metric;
  } cfi_decision_t;

  typedef struct packed {
    logic                  set_cell;
    logic [CELL_ID_W-1:0]  cell_value;
    soft_t                 real_soft;
    soft_t                 imag_soft;
    logic [SUBFRAME_W-1:0] subframe;
    logic                  typed;
    cfi_decision_t         decision;
  } stim_row_t;

  typedef enum logic [2:0] {
    SHAPE_CODEWORD,
    SHAPE_NOISE,
    SHAPE_FLOOR,
    SHAPE_EXTREME,
    SHAPE_WEAK
  } block_shape_e;

  logic clk_i;
  logic rst_ni;

  cfid_cfg_if cfg_if ();
  cfid_in_if  in_if ();
  cfid_out_if out_if ();

  cfi_indicator_detect DUT (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_if),
    .sample_i (in_if),
    .result_o (out_if)
  );

  // every soft value stuck at the most negative code: negation leaves it alone,
  // so codeword 3 (ten own bits, 22 others) wins with 12 * 32768
  stim_row_t directed_rows [NUM_DIRECTED] = '{
    '{1'b0, 9'd0,   SOFT_MIN,     SOFT_MIN,     4'd9,  1'b0, '{2'd0, 22'sd0}},
    '{1'b0, 9'd0,   SOFT_MIN,     SOFT_MIN,     4'd15, 1'b0, '{2'd0, 22'sd0}},
    '{1'b0, 9'd0,   SOFT_MIN,     SOFT_MIN,     4'd0,  1'b0, '{2'd0, 22'sd0}},
    '{1'b0, 9'd0,   SOFT_MIN,     SOFT_MIN,     4'd5,  1'b0, '{2'd0, 22'sd0}},
    '{1'b0, 9'd0,   SOFT_MIN,     SOFT_MIN,     4'd10, 1'b0, '{2'd0, 22'sd0}},
    '{1'b0, 9'd0,   SOFT_MIN,     SOFT_MIN,     4'd3,  1'b0, '{2'd0, 22'sd0}},
    '{1'b0, 9'd0,   SOFT_MIN,     SOFT_MIN,     4'd12, 1'b0, '{2'd0, 22'sd0}},
    '{1'b0, 9'd0,   SOFT_MIN,     SOFT_MIN,     4'd6,  1'b0, '{2'd0, 22'sd0}},
    '{1'b0, 9'd0,   SOFT_MIN,     SOFT_MIN,     4'd1,  1'b0, '{2'd0, 22'sd0}},
    '{1'b0, 9'd0,   SOFT_MIN,     SOFT_MIN,     4'd14, 1'b0, '{2'd0, 22'sd0}},
    '{1'b0, 9'd0,   SOFT_MIN,     SOFT_MIN,     4'd2,  1'b0, '{2'd0, 22'sd0}},
    '{1'b0, 9'd0,   SOFT_MIN,     SOFT_MIN,     4'd8,  1'b0, '{2'd0, 22'sd0}},
    '{1'b0, 9'd0,   SOFT_MIN,     SOFT_MIN,     4'd4,  1'b0, '{2'd0, 22'sd0}},
    '{1'b0, 9'd0,   SOFT_MIN,     SOFT_MIN,     4'd11, 1'b0, '{2'd0, 22'sd0}},
    '{1'b0, 9'd0,   SOFT_MIN,     SOFT_MIN,     4'd7,  1'b0, '{2'd0, 22'sd0}},
    '{1'b0, 9'd0,   SOFT_MIN,     SOFT_MIN,     4'd13, 1'b1, '{2'd3, 22'sd393216}},
    // out of range cell id and subframe on the first symbol
    '{1'b1, 9'd511, SOFT_MAX,     SOFT_MIN,     4'd15, 1'b0, '{2'd0, 22'sd0}},
    '{1'b0, 9'd0,   16'sd0,       -16'sd1,      4'd0,  1'b0, '{2'd0, 22'sd0}},
    '{1'b0, 9'd0,   16'sd1,       SOFT_MAX,     4'd9,  1'b0, '{2'd0, 22'sd0}},
    '{1'b0, 9'd0,   SOFT_MIN,     16'sd0,       4'd10, 1'b0, '{2'd0, 22'sd0}},
    '{1'b0, 9'd0,   -16'sd1,      16'sd1,       4'd5,  1'b0, '{2'd0, 22'sd0}},
    // cell id changes mid-block and must not touch the running scrambler
    '{1'b1, 9'd503, SOFT_MAX,     SOFT_MAX,     4'd15, 1'b0, '{2'd0, 22'sd0}},
    '{1'b0, 9'd0,   -16'sd12345,  16'sd23456,   4'd0,  1'b0, '{2'd0, 22'sd0}},
    '{1'b0, 9'd0,   SOFT_MIN,     SOFT_MAX,     4'd6,  1'b0, '{2'd0, 22'sd0}},
    '{1'b0, 9'd0,   16'sd7,       -16'sd7,      4'd9,  1'b0, '{2'd0, 22'sd0}}
  };

  // detector state as seen from outside
  logic [CELL_ID_W-1:0] model_cell_id;
  logic [POS_W-1:0]     model_pos;
  logic [WORD_W-1:0]    model_scramble;
  int                   model_metric [NUM_CW];

  cfi_decision_t expected_decisions [$];

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned hold_requests;
  int unsigned failures;
  int unsigned symbols_sent;
  int unsigned decisions_checked;
  int unsigned floor_hits;
  int unsigned cell_writes;
  int unsigned cfi_seen [4];

  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [GOLD_LEN-1:0] cinit_of(input logic [CELL_ID_W-1:0] cell_value,
                                                   input logic [SUBFRAME_W-1:0] sf);
    int unsigned c;
    c = (((2 * int'(cell_value) + 1) * (1 + int'(sf))) << 9) + int'(cell_value);
    return c[GOLD_LEN-1:0];
  endfunction

  // two length-31 lfsrs run past the 1600-step offset, output lsb first
  function automatic logic [WORD_W-1:0] scramble_word_for(input logic [GOLD_LEN-1:0] seed);
    logic [GOLD_LEN-1:0] x1;
    logic [GOLD_LEN-1:0] x2;
    logic [WORD_W-1:0]   w;
    logic                f1;
    logic                f2;
    x1 = GOLD_LEN'(1);
    x2 = seed;
    w  = '0;
    for (int n = 0; n < GOLD_NC + WORD_W; n++) begin
      f1 = x1[0] ^ x1[3];
      f2 = x2[0] ^ x2[1] ^ x2[2] ^ x2[3];
      if (n >= GOLD_NC) begin
        w[n - GOLD_NC] = x1[0] ^ x2[0];
      end
      x1 = {f1, x1[GOLD_LEN-1:1]};
      x2 = {f2, x2[GOLD_LEN-1:1]};
    end
    return w;
  endfunction

  // advances the detector state by one symbol, returns 1 when a decision falls out
  function automatic logic correlate_symbol(input soft_t re, input soft_t im,
                                            input logic [SUBFRAME_W-1:0] sf,
                                            output cfi_decision_t decision);
    soft_t            d;
    int               best;
    logic [CFI_W-1:0] cfi;
    int unsigned      j;
    decision = '0;
    if (model_pos == '0) begin
      model_scramble = scramble_word_for(cinit_of(model_cell_id, sf));
      model_metric   = '{default: 0};
    end
    for (int k = 0; k < 2; k++) begin
      j = 2 * model_pos + k;
      d = (k == 0) ? re : im;
      if (model_scramble[j]) begin
        d = -d;
      end
      for (int i = 0; i < NUM_CW; i++) begin
        model_metric[i] += (j % NUM_CW == i) ? int'(d) : -int'(d);
      end
    end
    if (model_pos != LAST_POS) begin
      model_pos = model_pos + 1'b1;
      return 1'b0;
    end
    model_pos = '0;
    best = START_METRIC;
    cfi  = CFI_DEFAULT;
    for (int i = 0; i < NUM_CW; i++) begin
      if (model_metric[i] > best) begin
        best = model_metric[i];
        cfi  = CFI_W'(i + 1);
      end
    end
    decision.cfi         = cfi;
    decision.best_metric = metric_t'(best);
    return 1'b1;
  endfunction

  task automatic send_symbol(input soft_t re, input soft_t im,
                             input logic [SUBFRAME_W-1:0] sf,
                             input logic typed, input cfi_decision_t typed_decision);
    cfi_decision_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.real_soft <= re;
    in_if.imag_soft <= im;
    in_if.subframe  <= sf;
    @(negedge clk_i);
    while (!in_if.ready) begin
      @(negedge clk_i);
    end
    @(posedge clk_i);
    symbols_sent++;
    if (correlate_symbol(re, im, sf, predicted)) begin
      expected_decisions.push_back(typed ? typed_decision : predicted);
    end
  endtask

  // input off, all decisions in, then let the queue and pipeline empty
  task automatic settle_block();
    in_if.valid <= 1'b0;
    while (expected_decisions.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_cell_id(input logic [CELL_ID_W-1:0] cell_value);
    cfg_if.valid   <= 1'b1;
    cfg_if.cell_id <= cell_value;
    @(negedge clk_i);
    while (!cfg_if.ready) begin
      @(negedge clk_i);
    end
    @(posedge clk_i);
    cfg_if.valid  <= 1'b0;
    model_cell_id = cell_value;
    cell_writes++;
  endtask

  task automatic set_pacing(input int unsigned send_pct, input int unsigned recv_pct);
    in_if.valid <= 1'b0;
    @(negedge clk_i);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    @(posedge clk_i);
  endtask

  task automatic request_long_hold();
    in_if.valid <= 1'b0;
    @(negedge clk_i);
    hold_requests++;
    @(posedge clk_i);
  endtask

  // finishes the current block with soft values shaped toward one outcome
  task automatic send_random_block();
    logic [WORD_W-1:0]     bits;
    logic [SUBFRAME_W-1:0] sf;
    block_shape_e          shape;
    int unsigned           start;
    int unsigned           target;
    int unsigned           j;
    int unsigned           roll;
    soft_t                 d;
    soft_t                 v [2];
    start = model_pos;
    sf = ($urandom_range(0, 5) == 0) ? SUBFRAME_W'($urandom_range(10, 15))
                                     : SUBFRAME_W'($urandom_range(0, 9));
    bits = (start == 0) ? scramble_word_for(cinit_of(model_cell_id, sf)) : model_scramble;
    roll = $urandom_range(0, 99);
    shape = (roll < 55) ? SHAPE_CODEWORD :
            (roll < 70) ? SHAPE_NOISE :
            (roll < 80) ? SHAPE_FLOOR :
            (roll < 90) ? SHAPE_EXTREME : SHAPE_WEAK;
    target = $urandom_range(0, NUM_CW - 1);
    for (int p = start; p <= LAST_POS; p++) begin
      for (int k = 0; k < 2; k++) begin
        j = 2 * p + k;
        case (shape)
          SHAPE_CODEWORD, SHAPE_WEAK: begin
            d = (shape == SHAPE_WEAK) ? soft_t'($urandom_range(0, 255))
                                      : soft_t'($urandom_range(0, 32767));
            if (j % NUM_CW != target) begin
              d = -d;
            end
            if (shape == SHAPE_CODEWORD && $urandom_range(0, 7) == 0) begin
              d = soft_t'($urandom);
            end
          end
          // all descrambled values large and positive: every metric below the floor
          SHAPE_FLOOR:   d = soft_t'($urandom_range(20000, 32767));
          SHAPE_EXTREME: d = EXTREME_SOFT[$urandom_range(0, NUM_EXTREMES - 1)];
          default:       d = soft_t'($urandom);
        endcase
        // pre-scramble so the block sees d after descrambling; extremes go in raw
        v[k] = (bits[j] && shape != SHAPE_EXTREME) ? -d : d;
      end
      send_symbol(v[0], v[1], (p == 0) ? sf : SUBFRAME_W'($urandom_range(0, 15)), 1'b0, '0);
    end
  endtask

  initial begin : result_sink
    int unsigned hold_left;
    int unsigned holds_served;
    hold_left     = 0;
    holds_served  = 0;
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (holds_served != hold_requests) begin
        holds_served = hold_requests;
        hold_left    = LONG_HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // inputs only change at the rising edge, so the falling edge sees the transaction
  always @(negedge clk_i) begin : result_check
    cfi_decision_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (expected_decisions.size() == 0) begin
        failures++;
        $display("%0t unexpected decision: cfi %0d metric %0d",
                 $time, out_if.cfi, out_if.best_metric);
      end else begin
        want = expected_decisions.pop_front();
        decisions_checked++;
        cfi_seen[want.cfi]++;
        if (want.best_metric == START_METRIC) begin
          floor_hits++;
        end
        if (out_if.cfi !== want.cfi) begin
          failures++;
          $display("%0t cfi mismatch: expected %0d, actual %0d", $time, want.cfi, out_if.cfi);
        end
        if (out_if.best_metric !== want.best_metric) begin
          failures++;
          $display("%0t best_metric mismatch: expected %0d, actual %0d",
                   $time, want.best_metric, out_if.best_metric);
        end
      end
    end
  end

  initial begin : watchdog
    #5_000_000;
    $display("%0t watchdog expired, %0d decisions outstanding", $time, expected_decisions.size());
    $display("cfi_indicator_detect test failed");
    $finish;
  end

  initial begin : stimulus
    logic [CELL_ID_W-1:0] next_cell;
    rst_ni          = 1'b0;
    in_if.valid     = 1'b0;
    in_if.real_soft = '0;
    in_if.imag_soft = '0;
    in_if.subframe  = '0;
    cfg_if.valid    = 1'b0;
    cfg_if.cell_id  = '0;
    send_idle_pct   = SEND_IDLE[0];
    recv_idle_pct   = RECV_IDLE[0];
    hold_requests   = 0;
    failures        = 0;
    symbols_sent    = 0;
    decisions_checked = 0;
    floor_hits      = 0;
    cell_writes     = 0;
    cfi_seen        = '{default: 0};
    model_cell_id   = '0;
    model_pos       = '0;
    model_scramble  = '0;
    model_metric    = '{default: 0};

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[r]) begin
      if (directed_rows[r].set_cell) begin
        settle_block();
        write_cell_id(directed_rows[r].cell_value);
      end
      send_symbol(directed_rows[r].real_soft, directed_rows[r].imag_soft,
                  directed_rows[r].subframe, directed_rows[r].typed,
                  directed_rows[r].decision);
    end

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      set_pacing(SEND_IDLE[phase], RECV_IDLE[phase]);
      for (int b = 0; b < BLOCKS_PER_PHASE; b++) begin
        if (b % 5 == 4) begin
          next_cell = (cell_writes < NUM_CELL_PRESETS) ? CELL_PRESETS[cell_writes]
                                                       : CELL_ID_W'($urandom_range(0, 511));
          settle_block();
          write_cell_id(next_cell);
        end
        // result side stalls for a long stretch while symbols keep coming
        if ((phase == 0 && b == 10) || (phase == 2 && b == 3)) begin
          request_long_hold();
        end
        send_random_block();
      end
    end

    settle_block();
    $display("covered %0d symbols, %0d decisions (cfi1 %0d, cfi2 %0d, cfi3 %0d, %0d at floor)",
             symbols_sent, decisions_checked, cfi_seen[1], cfi_seen[2], cfi_seen[3], floor_hits);
    $display("cell id rewritten %0d times across three pacing phases with long output stalls",
             cell_writes);
    if (failures == 0) begin
      $display("cfi_indicator_detect test passed");
    end else begin
      $display("cfi_indicator_detect test failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/cfid_pkg.sv
hdl/cfid_intf.sv
hdl/cfid_front.sv
hdl/cfid_queue.sv
hdl/cfid_back.sv
hdl/cfid_decide.sv
hdl/cfi_indicator_detect.sv
sim/cfi_indicator_detect_tb.sv
